[hdl/vasg_pkg.sv]
`default_nettype none

package vasg_pkg;

  // block length in frames (the last sample of a block is stored twice)
  localparam int BLOCK_SAMPLES = 600;
  localparam int POS_W = (BLOCK_SAMPLES > 2) ? $clog2(BLOCK_SAMPLES - 1) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SAMPLES - 2);

  // field widths
  localparam int ADC_W   = 10;
  localparam int DIV_W   = 7;
  localparam int LEVEL_W = 8;
  localparam int HOLD_W  = 15;
  localparam int BYTE_W  = 8;
  localparam int FRAME_W = 32;

  // serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = ADC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // stream payload widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  // register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_MIC_BALANCE   = 3'd0,
    REG_NOISE_DIVISOR = 3'd1,
    REG_START_LEVEL   = 3'd2,
    REG_HOLD_LENGTH   = 3'd3,
    REG_ALWAYS_RECORD = 3'd4
  } reg_idx_t;

  // reset values of the registers
  localparam logic [ADC_W-1:0]   MIC_BALANCE_RST   = 10'd270;
  localparam logic [DIV_W-1:0]   NOISE_DIVISOR_RST = 7'd3;
  localparam logic [LEVEL_W-1:0] START_LEVEL_RST   = 8'd48;
  localparam logic [HOLD_W-1:0]  HOLD_LENGTH_RST   = 15'd20000;

  // output byte mid-point and clamp limits
  localparam logic [ADC_W-1:0]  MID_LO   = 10'd127;
  localparam logic [ADC_W-1:0]  MID_HI   = 10'd128;
  localparam logic [BYTE_W-1:0] BYTE_MID = 8'd127;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

endpackage

`default_nettype wire

[hdl/voice_activated_sample_gate_top.sv]
// Voice-activated sample gate.
// Input stream (s_*): one 10-bit converter reading per item in s_tdata[9:0].
// Output stream (m_*): one result item per input item. m_tdata carries the
// clamped sample byte, the LED level and the running recorded frame count;
// m_tlast marks the last sample of a block, m_tuser says the block is kept.
// Configuration sits on an APB-style port, registers at byte address 4*i;
// write only while the block is idle.
// Timing: an accepted item runs through a restoring divider that produces
// one quotient bit per cycle, then the finish step updates the hold
// counter, block position and frame total and loads the output register.
// The block takes no new item while one is still in the divider or the
// finish step: s_tready is high only while the divider is free.
// If the receiver stalls, the finished result waits in the output register
// while the next item is already accepted and divided; that item then waits
// in the finish step until the output register is taken.
// Reset (rst, synchronous) restores the register defaults, clears the hold
// counter, block position and frame total, and empties the output register.
`default_nettype none

module voice_activated_sample_gate_top import vasg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [9:0] adc_sample
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // [7:0] sample_byte, [17:8] level,
                                               // [49:18] recorded_frames
  output logic                      m_tlast,   // block_end
  output logic                      m_tuser,   // keep_block
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  // configuration registers
  logic [ADC_W-1:0]   mic_balance;
  logic [DIV_W-1:0]   noise_divisor;
  logic [LEVEL_W-1:0] start_level;
  logic [HOLD_W-1:0]  hold_length;
  logic               always_record;

  // block state
  state_t             state;
  logic [STEP_W-1:0]  step;
  logic               neg;
  logic [ADC_W-1:0]   quo;
  logic [DIV_W-1:0]   rem;
  logic [HOLD_W-1:0]  hold_count;
  logic [POS_W-1:0]   block_position;
  logic [FRAME_W-1:0] frame_total;

  // output register
  logic [BYTE_W-1:0]  out_byte;
  logic [ADC_W-1:0]   out_level;
  logic [FRAME_W-1:0] out_frames;
  logic               out_end;
  logic               out_keep;

  logic               cfg_wr;
  logic               s_acc;
  logic [ADC_W-1:0]   raw;
  logic               raw_neg;
  logic [ADC_W-1:0]   raw_mag;
  logic [DIV_W-1:0]   div_eff;
  logic [DIV_W+1:0]   trial;
  logic [DIV_W-1:0]   rem_next;
  logic               out_free;
  logic               out_load;
  logic [BYTE_W-1:0]  byte_next;
  logic               loud;
  logic [HOLD_W-1:0]  hold_load;
  logic [HOLD_W-1:0]  hold_next;
  logic               end_next;
  logic               keep_next;
  logic [FRAME_W-1:0] frames_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      mic_balance   <= MIC_BALANCE_RST;
      noise_divisor <= NOISE_DIVISOR_RST;
      start_level   <= START_LEVEL_RST;
      hold_length   <= HOLD_LENGTH_RST;
      always_record <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_MIC_BALANCE:   mic_balance   <= pwdata[ADC_W-1:0];
        REG_NOISE_DIVISOR: noise_divisor <= pwdata[DIV_W-1:0];
        REG_START_LEVEL:   start_level   <= pwdata[LEVEL_W-1:0];
        REG_HOLD_LENGTH:   hold_length   <= pwdata[HOLD_W-1:0];
        REG_ALWAYS_RECORD: always_record <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_MIC_BALANCE:   prdata = DATA_W'(mic_balance);
      REG_NOISE_DIVISOR: prdata = DATA_W'(noise_divisor);
      REG_START_LEVEL:   prdata = DATA_W'(start_level);
      REG_HOLD_LENGTH:   prdata = DATA_W'(hold_length);
      REG_ALWAYS_RECORD: prdata = DATA_W'(always_record);
      default:           prdata = '0;
    endcase
  end

  // offset removal on the incoming item
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign raw      = s_tdata[ADC_W-1:0];
  assign raw_neg  = raw < mic_balance;
  assign raw_mag  = raw_neg ? (mic_balance - raw) : (raw - mic_balance);

  // one restoring divide step: shift in the next dividend bit, try subtract
  assign div_eff  = (noise_divisor == '0) ? DIV_W'(1) : noise_divisor;
  assign trial    = {1'b0, rem, quo[ADC_W-1]} - {2'b00, div_eff};
  assign rem_next = trial[DIV_W+1] ? {rem[DIV_W-2:0], quo[ADC_W-1]} : trial[DIV_W-1:0];

  // finish step: byte clamp, hold counter, block and frame bookkeeping
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_DONE) && out_free;

  always_comb begin
    if (neg) begin
      byte_next = (quo >= MID_LO) ? '0 : BYTE_MID - quo[BYTE_W-1:0];
    end else begin
      byte_next = (quo >= MID_HI) ? BYTE_MAX : BYTE_MID + quo[BYTE_W-1:0];
    end
  end

  assign loud        = !neg && (quo > ADC_W'(start_level));
  assign hold_load   = loud ? hold_length : hold_count;
  assign hold_next   = (hold_load != '0) ? hold_load - HOLD_W'(1) : '0;
  assign end_next    = (block_position >= POS_LAST);
  assign keep_next   = end_next && ((hold_next != '0) || always_record);
  assign frames_next = keep_next ? frame_total + FRAME_W'(BLOCK_SAMPLES) : frame_total;

  // sequencer, divider registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= '0;
      hold_count     <= '0;
      block_position <= '0;
      frame_total    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // output valid: set on a load, cleared when taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            neg   <= raw_neg;
            quo   <= raw_mag;
            rem   <= '0;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          quo  <= {quo[ADC_W-2:0], !trial[DIV_W+1]};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            hold_count     <= hold_next;
            block_position <= end_next ? '0 : block_position + POS_W'(1);
            frame_total    <= frames_next;
            out_byte       <= byte_next;
            out_level      <= quo;
            out_end        <= end_next;
            out_keep       <= keep_next;
            out_frames     <= frames_next;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {{(M_TDATA_W - BYTE_W - ADC_W - FRAME_W){1'b0}},
                    out_frames, out_level, out_byte};
  assign m_tlast = out_end;
  assign m_tuser = out_keep;

  // a kept block is always a block end
  a_keep_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser || m_tlast))
    else $error("keep flag without block end");

  // one item at a time: no new item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("item accepted while divider busy");

  // the frame total only ever grows by one block
  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    (frame_total != $past(frame_total)) |->
      (frame_total == $past(frame_total) + FRAME_W'(BLOCK_SAMPLES)))
    else $error("frame total moved by other than one block");

  // a finished item lands in the output register and frees the sequencer
  a_frame_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished item not handed to the output register");

endmodule

`default_nettype wire
